/* rtl/core/pll_setting_checker_top_defines.svh */
// assertion macros for the pll setting checker, included by pllchk_checker.sv
`ifndef PLL_SETTING_CHECKER_TOP_DEFINES_SVH
`define PLL_SETTING_CHECKER_TOP_DEFINES_SVH

// same-cycle implication, reset masks the check
`define PLLCHK_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pll checker assertion failed");

// next-cycle implication, reset masks the check
`define PLLCHK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pll checker assertion failed");

`endif

/* rtl/core/pllchk_pkg.sv */
// types and constants of the pll setting checker
`default_nettype none

package pllchk_pkg;

  localparam int PROD_W = 29;   // multiplier(9) times in_khz(20)
  localparam int REM_W  = 7;    // remainder stays below the 7-bit predivider

  localparam logic [19:0] IN_MIN_PER_M_LO = 20'd8000;   // plls 1 and 2
  localparam logic [19:0] IN_MIN_PER_M_HI = 20'd4000;   // plls 3 and 4
  localparam logic [20:0] IN_MAX_PER_M    = 21'd16000;
  localparam logic [8:0]  MUL_MIN         = 9'd25;
  localparam logic [8:0]  MUL_MAX_PLL1    = 9'd100;
  localparam logic [8:0]  MUL_MAX_OTHER   = 9'd200;
  localparam logic [PROD_W-1:0] VCO_MIN   = 29'd400000;
  localparam logic [PROD_W-1:0] VCO_MAX   = 29'd800000;
  localparam logic [7:0]  DIV_MAX         = 8'd128;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD_PLL = 3'd1,
    ST_INPUT   = 3'd2,
    ST_MUL     = 3'd3,
    ST_VCO     = 3'd4,
    ST_DIV     = 3'd5
  } status_t;

  // one request as it travels down the divider chain
  typedef struct packed {
    logic              valid;
    status_t           early_st;   // first failing check ahead of the vco check
    logic              div_bad;
    logic [6:0]        pre;
    logic [8:0]        mul;
    logic [7:0]        p_div;
    logic [7:0]        q_div;
    logic [7:0]        r_div;
    logic [REM_W-1:0]  rem;
    logic [PROD_W-1:0] work;       // dividend bits out, quotient bits in
  } stage_t;

endpackage

`default_nettype wire

/* rtl/core/pllchk_if.sv */
// request and result channel interfaces of the pll setting checker
`default_nettype none

interface pllchk_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] pll_number;
  logic [19:0] in_khz;
  logic [6:0] pre_divider;
  logic [8:0] multiplier;
  logic [7:0] p_divider;
  logic [7:0] q_divider;
  logic [7:0] r_divider;

  modport source (
    output valid, pll_number, in_khz, pre_divider, multiplier,
           p_divider, q_divider, r_divider,
    input  ready
  );
  modport sink (
    input  valid, pll_number, in_khz, pre_divider, multiplier,
           p_divider, q_divider, r_divider,
    output ready
  );
endinterface

interface pllchk_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [19:0] vco_khz;
  logic [22:0] ratio_word;
  logic [22:0] divider_word;
  logic [6:0]  control_word;

  modport source (
    output valid, status, vco_khz, ratio_word, divider_word, control_word,
    input  ready
  );
  modport sink (
    input  valid, status, vco_khz, ratio_word, divider_word, control_word,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/pllchk_front.sv */
// entry stage: range checks and the mul*in_khz product
`default_nettype none

module pllchk_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  pllchk_in_if.sink         in_req,
  output pllchk_pkg::stage_t stage_o
);

  pllchk_pkg::stage_t stage_r;
  pllchk_pkg::stage_t stage_nxt;
  pllchk_pkg::status_t early_st;
  logic [19:0] lo_bound;
  logic [20:0] hi_bound;
  logic        pll_ok;
  logic        in_bad;
  logic        mul_bad;
  logic [8:0]  mul_max;

  always_comb begin
    pll_ok   = in_req.pll_number inside {[3'd1:3'd4]};
    lo_bound = (in_req.pll_number <= 3'd2)
             ? 20'(in_req.pre_divider) * pllchk_pkg::IN_MIN_PER_M_LO
             : 20'(in_req.pre_divider) * pllchk_pkg::IN_MIN_PER_M_HI;
    hi_bound = 21'(in_req.pre_divider) * pllchk_pkg::IN_MAX_PER_M;
    in_bad   = (in_req.pre_divider == 7'd0) || (in_req.in_khz < lo_bound)
             || ({1'b0, in_req.in_khz} > hi_bound);
    mul_max  = (in_req.pll_number == 3'd1) ? pllchk_pkg::MUL_MAX_PLL1
                                            : pllchk_pkg::MUL_MAX_OTHER;
    mul_bad  = (in_req.multiplier < pllchk_pkg::MUL_MIN)
             || (in_req.multiplier > mul_max);

    if (!pll_ok) begin
      early_st = pllchk_pkg::ST_BAD_PLL;
    end else if (in_bad) begin
      early_st = pllchk_pkg::ST_INPUT;
    end else if (mul_bad) begin
      early_st = pllchk_pkg::ST_MUL;
    end else begin
      early_st = pllchk_pkg::ST_OK;
    end

    stage_nxt.valid    = in_req.valid;
    stage_nxt.early_st = early_st;
    stage_nxt.div_bad  = (in_req.p_divider > pllchk_pkg::DIV_MAX)
                       || (in_req.q_divider > pllchk_pkg::DIV_MAX)
                       || (in_req.r_divider > pllchk_pkg::DIV_MAX);
    stage_nxt.pre      = in_req.pre_divider;
    stage_nxt.mul      = in_req.multiplier;
    stage_nxt.p_div    = in_req.p_divider;
    stage_nxt.q_div    = in_req.q_divider;
    stage_nxt.r_div    = in_req.r_divider;
    stage_nxt.rem      = '0;
    stage_nxt.work     = pllchk_pkg::PROD_W'(in_req.multiplier)
                       * pllchk_pkg::PROD_W'(in_req.in_khz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;

endmodule

`default_nettype wire

/* rtl/core/pllchk_cell.sv */
// one restoring-division cell: produces one quotient bit per request
`default_nettype none

module pllchk_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire pllchk_pkg::stage_t stage_i,
  output pllchk_pkg::stage_t stage_o
);

  pllchk_pkg::stage_t stage_r;
  pllchk_pkg::stage_t stage_nxt;
  logic [pllchk_pkg::REM_W:0]   top;
  logic [pllchk_pkg::REM_W+1:0] diff;
  logic                         ge;

  always_comb begin
    // shift the next dividend bit into the partial remainder
    top  = {stage_i.rem, stage_i.work[pllchk_pkg::PROD_W-1]};
    diff = {1'b0, top} - {2'b00, stage_i.pre};
    ge   = !diff[pllchk_pkg::REM_W+1];

    stage_nxt      = stage_i;
    stage_nxt.rem  = ge ? diff[pllchk_pkg::REM_W-1:0] : top[pllchk_pkg::REM_W-1:0];
    stage_nxt.work = {stage_i.work[pllchk_pkg::PROD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;

endmodule

`default_nettype wire

/* rtl/core/pllchk_back.sv */
// final stage: vco check, word packing and the result register
`default_nettype none

module pllchk_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire pllchk_pkg::stage_t stage_i,
  pllchk_out_if.source       out_rsp
);

  logic        out_valid_r;
  logic [2:0]  status_r,  status_nxt;
  logic [19:0] vco_r,     vco_nxt;
  logic [22:0] ratio_r,   ratio_nxt;
  logic [22:0] divw_r,    divw_nxt;
  logic [6:0]  ctl_r,     ctl_nxt;
  pllchk_pkg::status_t st;
  logic        vco_bad;
  logic [7:0]  p_m1;
  logic [7:0]  q_m1;
  logic [7:0]  r_m1;

  always_comb begin
    vco_bad = (stage_i.work < pllchk_pkg::VCO_MIN) || (stage_i.work > pllchk_pkg::VCO_MAX);
    if (stage_i.early_st != pllchk_pkg::ST_OK) begin
      st = stage_i.early_st;
    end else if (vco_bad) begin
      st = pllchk_pkg::ST_VCO;
    end else if (stage_i.div_bad) begin
      st = pllchk_pkg::ST_DIV;
    end else begin
      st = pllchk_pkg::ST_OK;
    end

    // a zero divider leaves its field at zero
    p_m1 = (stage_i.p_div != 8'd0) ? stage_i.p_div - 8'd1 : 8'd0;
    q_m1 = (stage_i.q_div != 8'd0) ? stage_i.q_div - 8'd1 : 8'd0;
    r_m1 = (stage_i.r_div != 8'd0) ? stage_i.r_div - 8'd1 : 8'd0;

    status_nxt = st;
    if (st == pllchk_pkg::ST_OK) begin
      vco_nxt   = stage_i.work[19:0];
      ratio_nxt = {stage_i.pre - 7'd1, 7'd0, stage_i.mul - 9'd1};
      divw_nxt  = {r_m1[6:0], q_m1, p_m1};
      ctl_nxt   = {stage_i.r_div != 8'd0, stage_i.q_div != 8'd0,
                   stage_i.p_div != 8'd0, 3'b000, 1'b1};
    end else begin
      vco_nxt   = '0;
      ratio_nxt = '0;
      divw_nxt  = '0;
      ctl_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= stage_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status_r <= status_nxt;
      vco_r    <= vco_nxt;
      ratio_r  <= ratio_nxt;
      divw_r   <= divw_nxt;
      ctl_r    <= ctl_nxt;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = status_r;
  assign out_rsp.vco_khz      = vco_r;
  assign out_rsp.ratio_word   = ratio_r;
  assign out_rsp.divider_word = divw_r;
  assign out_rsp.control_word = ctl_r;

endmodule

`default_nettype wire

/* rtl/core/pll_setting_checker_top.sv */
// pll setting checker top level: entry stage, divider cell chain, result stage
//
// Checks one pll setting request per cycle and returns one result per request,
// in order. A request passes through one entry stage that does the range
// checks and the 9x20 multiply, a chain of 29 identical divider cells that
// each settle one bit of mul*in_khz/pre, and the result register.
// The chain is a lockstep pipeline: it moves whenever the result register is
// empty or being taken, so throughput is one request per cycle under a
// free-running sink. Holding out_rsp.ready low stalls the whole chain.
`default_nettype none

module pll_setting_checker_top (
  input  wire logic clk,
  input  wire logic rst_n,
  pllchk_in_if.sink    in_req,
  pllchk_out_if.source out_rsp
);

  pllchk_pkg::stage_t chain [0:pllchk_pkg::PROD_W];
  logic adv;

  assign adv          = !out_rsp.valid || out_rsp.ready;
  assign in_req.ready = adv;

  pllchk_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_req  (in_req),
    .stage_o (chain[0])
  );

  for (genvar i = 0; i < pllchk_pkg::PROD_W; i++) begin : g_cell
    pllchk_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .stage_i (chain[i]),
      .stage_o (chain[i+1])
    );
  end

  pllchk_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .stage_i (chain[pllchk_pkg::PROD_W]),
    .out_rsp (out_rsp)
  );

endmodule

`default_nettype wire

/* rtl/core/pllchk_checker.sv */
// port-level assertions for the pll setting checker and their bind
`default_nettype none
`include "pll_setting_checker_top_defines.svh"

module pllchk_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status,
  input wire logic [19:0] vco_khz,
  input wire logic [22:0] ratio_word,
  input wire logic [22:0] divider_word,
  input wire logic [6:0]  control_word
);

  // a stalled result stays offered
  `PLLCHK_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // a stalled result keeps its status
  `PLLCHK_ASSERT_NEXT(a_status_hold, clk, rst_n, out_valid && !out_ready, $stable(status))

  // a passing request always has its vco in the legal band and control bit 0 set
  `PLLCHK_ASSERT_IMPLY(a_ok_vco, clk, rst_n, out_valid && (status == pllchk_pkg::ST_OK), (vco_khz >= 20'd400000) && (vco_khz <= 20'd800000) && (control_word[0] == 1'b1))

  // a failing request carries no programming words
  `PLLCHK_ASSERT_IMPLY(a_err_zero, clk, rst_n, out_valid && (status != pllchk_pkg::ST_OK), (vco_khz == '0) && (ratio_word == '0) && (divider_word == '0) && (control_word == '0))

endmodule

bind pll_setting_checker_top pllchk_checker u_pllchk_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_rsp.valid),
  .out_ready    (out_rsp.ready),
  .status       (out_rsp.status),
  .vco_khz      (out_rsp.vco_khz),
  .ratio_word   (out_rsp.ratio_word),
  .divider_word (out_rsp.divider_word),
  .control_word (out_rsp.control_word)
);

`default_nettype wire

/* dv/tb_pll_setting_checker_top.sv */
// testbench for the pll setting checker: random and corner requests checked against a predictor

typedef struct packed {
  logic [2:0]  pll;
  logic [19:0] in_khz;
  logic [6:0]  pre;
  logic [8:0]  mul;
  logic [7:0]  p_div;
  logic [7:0]  q_div;
  logic [7:0]  r_div;
} pll_request_t;

typedef struct packed {
  pllchk_pkg::status_t status;
  logic [19:0]         vco_khz;
  logic [22:0]         ratio_word;
  logic [22:0]         divider_word;
  logic [6:0]          control_word;
} pll_verdict_t;

class setting_scoreboard;
  pll_verdict_t pending_verdicts[$];
  int           mismatches = 0;

  // works out status and programming words of one request
  function pll_verdict_t judge_setting(pll_request_t r);
    pll_verdict_t     v;
    int unsigned      floor_per_m;
    int unsigned      mul_cap;
    longint unsigned  vco;
    v = '0;
    if (r.pll < 3'd1 || r.pll > 3'd4) begin
      v.status = pllchk_pkg::ST_BAD_PLL;
      return v;
    end
    floor_per_m = (r.pll <= 3'd2) ? 8000 : 4000;
    mul_cap = (r.pll == 3'd1) ? 100 : 200;
    if (r.pre == 7'd0 || r.in_khz < r.pre * floor_per_m || r.in_khz > r.pre * 16000) begin
      v.status = pllchk_pkg::ST_INPUT;
      return v;
    end
    if (r.mul < 25 || r.mul > mul_cap) begin
      v.status = pllchk_pkg::ST_MUL;
      return v;
    end
    vco = (longint'(r.mul) * longint'(r.in_khz)) / longint'(r.pre);
    if (vco < 400000 || vco > 800000) begin
      v.status = pllchk_pkg::ST_VCO;
      return v;
    end
    if (r.p_div > 8'd128 || r.q_div > 8'd128 || r.r_div > 8'd128) begin
      v.status = pllchk_pkg::ST_DIV;
      return v;
    end
    v.status = pllchk_pkg::ST_OK;
    v.vco_khz = vco[19:0];
    v.ratio_word = {r.pre - 7'd1, 7'd0, r.mul - 9'd1};
    // a zero divider leaves its field at zero
    v.divider_word = {(r.r_div != 8'd0) ? r.r_div[6:0] - 7'd1 : 7'd0,
                      (r.q_div != 8'd0) ? r.q_div - 8'd1 : 8'd0,
                      (r.p_div != 8'd0) ? r.p_div - 8'd1 : 8'd0};
    v.control_word = {r.r_div != 8'd0, r.q_div != 8'd0, r.p_div != 8'd0, 3'b000, 1'b1};
    return v;
  endfunction

  function void note_request(pll_request_t r);
    pending_verdicts.push_back(judge_setting(r));
  endfunction

  task report(string what, logic [22:0] got, logic [22:0] want);
    if (mismatches < 100)
      $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  task check_result(pll_verdict_t got);
    pll_verdict_t want;
    if (pending_verdicts.size() == 0) begin
      report("result with no request outstanding", 23'(got.status), 23'd0);
      return;
    end
    want = pending_verdicts.pop_front();
    if (got.status !== want.status)
      report("status", 23'(got.status), 23'(want.status));
    if (got.vco_khz !== want.vco_khz)
      report("vco_khz", 23'(got.vco_khz), 23'(want.vco_khz));
    if (got.ratio_word !== want.ratio_word)
      report("ratio_word", got.ratio_word, want.ratio_word);
    if (got.divider_word !== want.divider_word)
      report("divider_word", got.divider_word, want.divider_word);
    if (got.control_word !== want.control_word)
      report("control_word", 23'(got.control_word), 23'(want.control_word));
  endtask
endclass

module tb_pll_setting_checker_top;

  localparam int RANDOM_REQUESTS = 1625;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int DRAIN_CYCLES    = 40;

  logic clk = 1'b0;
  logic rst_n;

  pllchk_in_if  in_req();
  pllchk_out_if out_rsp();

  setting_scoreboard sb = new();
  int  cycle_count = 0;
  int  accepted_requests = 0;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;
  bit  pressure_done = 1'b0;

  pll_setting_checker_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp)
  );

  always #2 clk = ~clk;

  // mostly short gaps, now and then a long one, none while steady
  function automatic int pick_gap(bit steady);
    int unsigned roll;
    if (steady)
      return 0;
    roll = $urandom_range(99);
    if (roll < 55)
      return 0;
    if (roll < 85)
      return $urandom_range(3, 1);
    if (roll < 97)
      return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic pll_request_t mk_req(int pll, int in_khz, int pre, int mul,
                                          int p, int q, int r);
    pll_request_t req;
    req.pll = 3'(pll);
    req.in_khz = 20'(in_khz);
    req.pre = 7'(pre);
    req.mul = 9'(mul);
    req.p_div = 8'(p);
    req.q_div = 8'(q);
    req.r_div = 8'(r);
    return req;
  endfunction

  function automatic logic [7:0] random_divider();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15)
      return 8'd0;
    if (roll < 20)
      return 8'($urandom_range(255, 129));
    return 8'($urandom_range(128, 1));
  endfunction

  // mostly well-formed requests near the legal region, some broken, some noise
  function automatic pll_request_t random_request();
    pll_request_t req;
    int unsigned  kind, pick;
    int unsigned  fin_lo, fin_hi, mul_cap, mul_lo, mul_hi;
    kind = $urandom_range(99);
    if (kind < 20) begin
      req.pll = 3'($urandom);
      req.in_khz = 20'($urandom);
      req.pre = 7'($urandom);
      req.mul = 9'($urandom);
      req.p_div = 8'($urandom);
      req.q_div = 8'($urandom);
      req.r_div = 8'($urandom);
      return req;
    end
    req.pll = 3'($urandom_range(4, 1));
    req.pre = 7'(($urandom_range(9) == 0) ? $urandom_range(127, 1) : $urandom_range(12, 1));
    fin_lo = req.pre * ((req.pll <= 3'd2) ? 8000 : 4000);
    fin_hi = req.pre * 16000;
    if (fin_hi > 1048575)
      fin_hi = 1048575;
    pick = $urandom_range(9);
    req.in_khz = 20'((pick == 0) ? fin_lo : (pick == 1) ? fin_hi
                                                        : $urandom_range(fin_hi, fin_lo));
    mul_cap = (req.pll == 3'd1) ? 100 : 200;
    mul_lo = (400000 * req.pre + req.in_khz - 1) / req.in_khz;
    if (mul_lo < 25)
      mul_lo = 25;
    mul_hi = (800000 * req.pre) / req.in_khz;
    if (mul_hi > mul_cap)
      mul_hi = mul_cap;
    if (mul_lo <= mul_hi) begin
      pick = $urandom_range(9);
      req.mul = 9'((pick == 0) ? mul_lo : (pick == 1) ? mul_hi
                                                      : $urandom_range(mul_hi, mul_lo));
    end else begin
      req.mul = 9'($urandom_range(mul_cap, 25));
    end
    req.p_div = random_divider();
    req.q_div = random_divider();
    req.r_div = random_divider();
    if (kind < 35) begin
      case ($urandom_range(5))
        0: req.pll = 3'($urandom);
        1: req.in_khz = 20'($urandom_range(1) ? fin_lo - 1 : fin_hi + 1);
        2: req.pre = 7'($urandom);
        3: req.mul = 9'($urandom);
        4: req.mul = 9'($urandom_range(1) ? mul_lo - 1 : mul_hi + 1);
        default: req.pre = 7'd0;
      endcase
    end
    return req;
  endfunction

  task automatic send_request(pll_request_t req);
    int gap;
    if ($urandom_range(49) == 0)
      tx_steady = !tx_steady;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid       <= 1'b1;
    in_req.pll_number  <= req.pll;
    in_req.in_khz      <= req.in_khz;
    in_req.pre_divider <= req.pre;
    in_req.multiplier  <= req.mul;
    in_req.p_divider   <= req.p_div;
    in_req.q_divider   <= req.q_div;
    in_req.r_divider   <= req.r_div;
    do @(posedge clk); while (!in_req.ready);
  endtask

  // watch both channels at the edge and keep the run bounded
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else if (rst_n) begin
      if (in_req.valid && in_req.ready) begin
        sb.note_request(pll_request_t'{in_req.pll_number, in_req.in_khz, in_req.pre_divider,
                                       in_req.multiplier, in_req.p_divider,
                                       in_req.q_divider, in_req.r_divider});
        accepted_requests <= accepted_requests + 1;
      end
      if (out_rsp.valid && out_rsp.ready)
        sb.check_result(pll_verdict_t'{pllchk_pkg::status_t'(out_rsp.status),
                                       out_rsp.vco_khz, out_rsp.ratio_word,
                                       out_rsp.divider_word, out_rsp.control_word});
    end
  end

  // result side: random stalls plus one long hold-off to back up the pipeline
  initial begin
    int hold;
    out_rsp.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(49) == 0)
        rx_steady = !rx_steady;
      if (!pressure_done && accepted_requests >= 300) begin
        pressure_done = 1'b1;
        hold = HOLD_OFF_CYCLES;
      end else begin
        hold = pick_gap(rx_steady);
      end
      if (hold > 0) begin
        out_rsp.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_rsp.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    pll_request_t corner[$];
    rst_n              <= 1'b0;
    in_req.valid       <= 1'b0;
    in_req.pll_number  <= '0;
    in_req.in_khz      <= '0;
    in_req.pre_divider <= '0;
    in_req.multiplier  <= '0;
    in_req.p_divider   <= '0;
    in_req.q_divider   <= '0;
    in_req.r_divider   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // bad pll numbers
    corner.push_back(mk_req(0, 12000, 1, 50, 1, 1, 1));
    corner.push_back(mk_req(5, 12000, 1, 50, 1, 1, 1));
    corner.push_back(mk_req(7, 1048575, 127, 511, 255, 255, 255));
    corner.push_back(mk_req(6, 0, 0, 0, 0, 0, 0));
    // zero predivider, input range edges
    corner.push_back(mk_req(1, 12000, 0, 50, 1, 1, 1));
    corner.push_back(mk_req(1, 7999, 1, 60, 1, 1, 1));
    corner.push_back(mk_req(3, 3999, 1, 120, 1, 1, 1));
    corner.push_back(mk_req(2, 16001, 1, 30, 1, 1, 1));
    corner.push_back(mk_req(1, 1016000, 127, 50, 128, 0, 1));
    // multiplier edges
    corner.push_back(mk_req(1, 10000, 1, 24, 1, 1, 1));
    corner.push_back(mk_req(1, 8000, 1, 101, 1, 1, 1));
    corner.push_back(mk_req(4, 4000, 1, 201, 1, 1, 1));
    corner.push_back(mk_req(4, 1048575, 127, 511, 255, 255, 255));
    corner.push_back(mk_req(1, 16000, 1, 25, 3, 3, 3));
    // vco edges
    corner.push_back(mk_req(3, 4000, 1, 100, 2, 2, 2));
    corner.push_back(mk_req(2, 8000, 1, 100, 0, 0, 0));
    corner.push_back(mk_req(4, 4000, 1, 200, 0, 5, 0));
    corner.push_back(mk_req(2, 16000, 1, 51, 1, 1, 1));
    corner.push_back(mk_req(3, 4000, 1, 99, 1, 1, 1));
    corner.push_back(mk_req(3, 12001, 3, 100, 3, 4, 5));
    // divider limits
    corner.push_back(mk_req(1, 8000, 1, 50, 128, 128, 128));
    corner.push_back(mk_req(1, 8000, 1, 50, 129, 1, 1));
    corner.push_back(mk_req(1, 8000, 1, 50, 1, 129, 1));
    corner.push_back(mk_req(2, 16000, 1, 50, 1, 0, 255));
    corner.push_back(mk_req(4, 1048575, 127, 90, 7, 0, 128));

    foreach (corner[i])
      send_request(corner[i]);
    repeat (RANDOM_REQUESTS)
      send_request(random_request());
    in_req.valid <= 1'b0;
    // let the monitor note the last request before looking at the queue
    @(posedge clk);

    while (sb.pending_verdicts.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule
